@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the top level of the FU depacketizer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every rising clock edge outside reset.
`define ASSERT_PROP(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Condition must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(name, clk, rst, cond) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(name, clk, rst, prop)
`define ASSERT_NEVER(name, clk, rst, cond)

`endif

`endif

@@ hw/rtl/rtpfu_pkg.sv @@
// Package: word types, command type and constants of the FU depacketizer.
`default_nettype none

package rtpfu_pkg;

  // NAL length counter width, fixed by the output word
  localparam int NAL_LEN_BITS = 24;
  localparam logic [NAL_LEN_BITS-1:0] NAL_LEN_MAX = '1;

  // Default depth of the command queue between front and back
  localparam int CMD_FIFO_DEPTH = 4;

  // Packet header parsing
  localparam logic [3:0] RTP_HDR_LEN  = 4'd12;
  localparam logic [3:0] PREFIX_MAX   = 4'd15;
  localparam logic [7:0] RTP_VER_BIT  = 8'h80;
  localparam logic [7:0] RTP_PT_MASK  = 8'h60;

  // NAL and FU header fields
  localparam logic [7:0] AVC_TYPE_MASK  = 8'h1F;
  localparam logic [4:0] AVC_FU_TYPE    = 5'd28;
  localparam logic [5:0] HEVC_FU_TYPE   = 6'd49;
  localparam logic [7:0] HEVC_TYPE_MASK = 8'h3F;
  localparam logic [7:0] AVC_NRI_MASK   = 8'hE0;
  localparam logic [7:0] HEVC_KEEP_MASK = 8'h81;

  // Start code bytes
  localparam logic [7:0] SC_ZERO = 8'h00;
  localparam logic [7:0] SC_LAST = 8'h01;
  localparam logic [2:0] SC_LEN  = 3'd4;

  // Packet kinds
  localparam logic [1:0] KIND_UNDECIDED = 2'd0;
  localparam logic [1:0] KIND_SINGLE    = 2'd1;
  localparam logic [1:0] KIND_AVC_FU    = 2'd2;
  localparam logic [1:0] KIND_HEVC_FU   = 2'd3;

  typedef struct packed {
    logic [7:0] pkt_byte;
    logic       pkt_last;
  } pkt_word_t;

  typedef struct packed {
    logic [7:0]              out_byte;
    logic                    byte_valid;
    logic                    nal_end;
    logic [NAL_LEN_BITS-1:0] nal_length;
  } bs_word_t;

  // One classified packet byte: optional start code, up to two data bytes,
  // optional end of NAL with its final length.
  typedef struct packed {
    logic                    start;
    logic [1:0]              ndata;
    logic [7:0]              d0;
    logic [7:0]              d1;
    logic                    nal_end;
    logic [NAL_LEN_BITS-1:0] nal_length;
  } cmd_t;

endpackage

`default_nettype wire

@@ hw/rtl/rtpfu_front.sv @@
// Front end: parses packet bytes and turns them into output commands; a byte that emits nothing pushes none.
`default_nettype none

module rtpfu_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               accept,
  input  wire rtpfu_pkg::pkt_word_t pkt_data,
  output rtpfu_pkg::cmd_t         cmd,
  output logic                    cmd_push
);
  import rtpfu_pkg::*;

  // Packet parse state
  logic [3:0]              prefix_pos;
  logic [7:0]              held_first;
  logic [7:0]              held_second;
  logic                    rtp_present;
  logic [1:0]              packet_kind;
  logic                    fu_end_seen;
  logic [NAL_LEN_BITS-1:0] nal_count;

  logic [7:0]              held_first_next;
  logic [7:0]              held_second_next;
  logic [1:0]              packet_kind_next;
  logic                    fu_end_seen_next;
  logic [NAL_LEN_BITS-1:0] nal_count_next;

  logic [7:0]  b;
  logic        last;
  logic        q_ok;
  logic [3:0]  q;
  logic        rtp_set;
  logic        st;
  logic [1:0]  nd;
  logic [7:0]  d0;
  logic [7:0]  d1;
  logic        single_end;
  logic        end_now;
  logic [2:0]  emitted;
  logic [NAL_LEN_BITS-1:0] base;
  logic [NAL_LEN_BITS:0]   sum;

  function automatic logic is_avc_fu(input logic [7:0] p0);
    return (p0 & AVC_TYPE_MASK) == {3'b000, AVC_FU_TYPE};
  endfunction

  function automatic logic is_hevc_fu(input logic [7:0] p0);
    return p0[6:1] == HEVC_FU_TYPE;
  endfunction

  assign b    = pkt_data.pkt_byte;
  assign last = pkt_data.pkt_last;

  // Payload position of this byte; none inside the RTP header
  always_comb begin
    q_ok    = 1'b0;
    q       = '0;
    rtp_set = 1'b0;
    priority if (prefix_pos == 4'd0) begin
      q_ok = 1'b1;
    end else if (prefix_pos == 4'd1 && !rtp_present && (held_first & RTP_VER_BIT) != 8'h00
                 && (b & RTP_PT_MASK) != 8'h00) begin
      rtp_set = 1'b1;
    end else if (rtp_present) begin
      if (prefix_pos >= RTP_HDR_LEN) begin
        q_ok = 1'b1;
        q    = prefix_pos - RTP_HDR_LEN;
      end
    end else begin
      q_ok = 1'b1;
      q    = prefix_pos;
    end
  end

  // Classify the byte and pick what it emits
  always_comb begin
    held_first_next  = held_first;
    held_second_next = held_second;
    packet_kind_next = packet_kind;
    fu_end_seen_next = fu_end_seen;
    st         = 1'b0;
    nd         = 2'd0;
    d0         = '0;
    d1         = '0;
    single_end = 1'b0;
    if (q_ok && q == 4'd0) begin
      held_first_next = b;
      if (last && !is_avc_fu(b) && !is_hevc_fu(b)) begin
        st         = 1'b1;
        nd         = 2'd1;
        d0         = b;
        single_end = 1'b1;
      end
    end else if (q_ok && q == 4'd1) begin
      held_second_next = b;
      if (is_avc_fu(held_first)) begin
        packet_kind_next = KIND_AVC_FU;
        if (b[7]) begin
          st = 1'b1;
          nd = 2'd1;
          d0 = (held_first & AVC_NRI_MASK) | (b & AVC_TYPE_MASK);
        end else begin
          fu_end_seen_next = b[6];
        end
      end else if (is_hevc_fu(held_first)) begin
        packet_kind_next = KIND_HEVC_FU;
      end else begin
        packet_kind_next = KIND_SINGLE;
        st = 1'b1;
        nd = 2'd2;
        d0 = held_first;
        d1 = b;
      end
    end else if (q_ok && q == 4'd2 && packet_kind == KIND_HEVC_FU) begin
      if (b[7]) begin
        st = 1'b1;
        nd = 2'd2;
        d0 = (held_first & HEVC_KEEP_MASK) | ((b & HEVC_TYPE_MASK) << 1);
        d1 = held_second;
      end else begin
        fu_end_seen_next = b[6];
      end
    end else if (q_ok && q >= 4'd2 && packet_kind != KIND_UNDECIDED) begin
      nd = 2'd1;
      d0 = b;
    end
  end

  // NAL end and saturating length
  always_comb begin
    end_now = last && (single_end || packet_kind_next == KIND_SINGLE ||
              ((packet_kind_next == KIND_AVC_FU || packet_kind_next == KIND_HEVC_FU)
               && fu_end_seen_next));
    emitted = (st ? SC_LEN : 3'd0) + {1'b0, nd};
    base    = st ? '0 : nal_count;
    sum     = {1'b0, base} + {{(NAL_LEN_BITS-2){1'b0}}, emitted};
    nal_count_next = sum[NAL_LEN_BITS] ? NAL_LEN_MAX : sum[NAL_LEN_BITS-1:0];
  end

  assign cmd.start      = st;
  assign cmd.ndata      = nd;
  assign cmd.d0         = d0;
  assign cmd.d1         = d1;
  assign cmd.nal_end    = end_now;
  assign cmd.nal_length = end_now ? nal_count_next : '0;
  assign cmd_push       = accept && (emitted != 3'd0 || end_now);

  // State update per accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_pos  <= '0;
      held_first  <= '0;
      held_second <= '0;
      rtp_present <= 1'b0;
      packet_kind <= KIND_UNDECIDED;
      fu_end_seen <= 1'b0;
      nal_count   <= '0;
    end else if (accept) begin
      held_first  <= held_first_next;
      held_second <= held_second_next;
      nal_count   <= nal_count_next;
      if (last) begin
        prefix_pos  <= '0;
        rtp_present <= 1'b0;
        packet_kind <= KIND_UNDECIDED;
        fu_end_seen <= 1'b0;
      end else begin
        prefix_pos  <= (prefix_pos < PREFIX_MAX) ? prefix_pos + 4'd1 : PREFIX_MAX;
        rtp_present <= rtp_present | rtp_set;
        packet_kind <= packet_kind_next;
        fu_end_seen <= fu_end_seen_next;
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/rtpfu_cmd_fifo.sv @@
// Command queue between the parsing front end and the output back end.
`default_nettype none

module rtpfu_cmd_fifo #(
  parameter int DEPTH = rtpfu_pkg::CMD_FIFO_DEPTH
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire rtpfu_pkg::cmd_t din,
  input  wire logic            pop,
  output rtpfu_pkg::cmd_t      head,
  output logic                 nonempty,
  output logic                 full
);
  import rtpfu_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] level;

  assign head     = slots[rd_ptr];
  assign nonempty = level != '0;
  assign full     = level == CW'(DEPTH);

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   level <= level + 1'b1;
        2'b01:   level <= level - 1'b1;
        default: level <= level;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/rtpfu_back.sv @@
// Back end: expands queued commands into stream words, one per cycle unless bs_stall holds the output.
`default_nettype none

module rtpfu_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire rtpfu_pkg::cmd_t   head,
  input  wire logic              head_valid,
  output logic                   pop,
  output logic                   bs_valid,
  input  wire logic              bs_stall,
  output rtpfu_pkg::bs_word_t    bs_data
);
  import rtpfu_pkg::*;

  logic [2:0] idx;
  logic [2:0] total;
  logic [2:0] cnt;
  logic [2:0] j;
  logic       bare;
  logic       last;
  logic       in_code;
  logic       load;
  bs_word_t   res;

  // Word at the current position within the command
  always_comb begin
    total   = (head.start ? SC_LEN : 3'd0) + {1'b0, head.ndata};
    bare    = total == 3'd0;
    cnt     = bare ? 3'd1 : total;
    last    = idx == cnt - 3'd1;
    in_code = head.start && idx < SC_LEN;
    j       = head.start ? idx - SC_LEN : idx;
    if (bare) begin
      res.out_byte = '0;
    end else if (in_code) begin
      res.out_byte = (idx == SC_LEN - 3'd1) ? SC_LAST : SC_ZERO;
    end else begin
      res.out_byte = j[0] ? head.d1 : head.d0;
    end
    res.byte_valid = !bare;
    res.nal_end    = head.nal_end && last;
    res.nal_length = (head.nal_end && last) ? head.nal_length : '0;
  end

  assign load = head_valid && (!bs_valid || !bs_stall);
  assign pop  = load && last;

  // Output register
  always_ff @(posedge clk) begin
    if (load) begin
      bs_data <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bs_valid <= 1'b0;
      idx      <= '0;
    end else if (load) begin
      bs_valid <= 1'b1;
      idx      <= last ? 3'd0 : idx + 3'd1;
    end else if (!bs_stall) begin
      bs_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/rtp_fu_nal_reassembler.sv @@
// Top level: RTP FU depacketizer producing an Annex-B byte stream.
//
//  channel | dir | handshake             | word
//  --------+-----+-----------------------+------------------------------------
//  pkt     | in  | pkt_valid / pkt_stall | pkt_byte, pkt_last
//  bs      | out | bs_valid  / bs_stall  | out_byte, byte_valid, nal_end,
//          |     |                       | nal_length
//
// One packet byte is taken per cycle while the command queue has room.
// The back end delivers one stream word per cycle unless bs_stall holds it;
// a start byte expands to five or six words, which the FIFO_DEPTH-entry command
// queue absorbs; commands pass through the queue and then the output register.
// rst is synchronous and clears all parse state; no memory clearing pass.
// bs_stall holds the output register; pkt_stall rises only when the queue fills.
`default_nettype none
`include "assert_macros.svh"

module rtp_fu_nal_reassembler #(
  parameter int FIFO_DEPTH = rtpfu_pkg::CMD_FIFO_DEPTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 pkt_valid,
  output logic                      pkt_stall,
  input  wire rtpfu_pkg::pkt_word_t pkt_data,
  output logic                      bs_valid,
  input  wire logic                 bs_stall,
  output rtpfu_pkg::bs_word_t       bs_data
);
  import rtpfu_pkg::*;

  logic accept;
  cmd_t cmd;
  logic cmd_push;
  cmd_t head;
  logic head_valid;
  logic fifo_full;
  logic pop;
  logic out_bare;
  logic out_open;
  logic out_end_byte;

  assign pkt_stall = fifo_full;
  assign accept    = pkt_valid && !pkt_stall;

  // Parse and classify
  rtpfu_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .pkt_data (pkt_data),
    .cmd      (cmd),
    .cmd_push (cmd_push)
  );

  // Command queue
  rtpfu_cmd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (cmd_push),
    .din      (cmd),
    .pop      (pop),
    .head     (head),
    .nonempty (head_valid),
    .full     (fifo_full)
  );

  // Serialize to the stream
  rtpfu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .bs_valid   (bs_valid),
    .bs_stall   (bs_stall),
    .bs_data    (bs_data)
  );

  // Checks
  assign out_bare     = bs_valid && !bs_data.byte_valid;
  assign out_open     = bs_valid && !bs_data.nal_end;
  assign out_end_byte = bs_valid && bs_data.nal_end && bs_data.byte_valid;

  `ASSERT_NEVER(a_push_when_full, clk, rst, cmd_push && fifo_full)
  `ASSERT_PROP(a_bare_is_end, clk, rst, out_bare |-> (bs_data.nal_end && bs_data.out_byte == 8'h00))
  `ASSERT_PROP(a_len_only_at_end, clk, rst, out_open |-> (bs_data.nal_length == '0))
  `ASSERT_PROP(a_end_has_len, clk, rst, out_end_byte |-> (bs_data.nal_length != '0))

endmodule

`default_nettype wire
